// ===== rtl/core/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mexp_pkg
// Shared types and constants of the modular exponentiation block.
// ============================================================================
package mexp_pkg;

    // Configuration port address width and register word index.
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam bit REG_MODULUS   = 1'b0;

    // Modulus after reset.
    localparam int MODULUS_RESET = 23;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take a new base and exponent, result starts at one
        logic clear_acc;  // force the result to zero
        logic red_start;  // form both products and load the reducers
        logic red_step;   // one remainder bit in each reducer
        logic update;     // commit the reduced values, shift the exponent
    } mexp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_zero;   // no set exponent bits remain
        logic mod_zero;   // the modulus is zero
        logic red_last;   // the reducers take their final step this cycle
    } mexp_status_t;

endpackage

// ===== rtl/core/mexp_modred.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mexp_modred
// Bit-serial modular reducer: restoring remainder of a double-width value.
// ============================================================================
module mexp_modred #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       load,
    input  logic                       step,
    input  logic [2*OPERAND_WIDTH-1:0] product,
    input  logic [OPERAND_WIDTH-1:0]   modulus,
    output logic [OPERAND_WIDTH-1:0]   remainder
);

    localparam int W = OPERAND_WIDTH;

    logic [2*W-1:0] prod_reg;
    logic [W-1:0]   rem_reg;
    logic [W:0]     trial;
    logic [W:0]     diff;

    // The partial remainder stays below the modulus, so one shift and one
    // conditional subtract per bit keep it in W bits.
    assign trial     = {rem_reg, prod_reg[2*W-1]};
    assign diff      = trial - {1'b0, modulus};
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= product;
            rem_reg  <= '0;
        end
        else if (step)
        begin
            prod_reg <= {prod_reg[2*W-2:0], 1'b0};
            if (trial >= {1'b0, modulus})
            begin
                rem_reg <= diff[W-1:0];
            end
            else
            begin
                rem_reg <= trial[W-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/mexp_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mexp_datapath
// Base, exponent and result registers with two product and reduction lanes.
// ============================================================================
module mexp_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mexp_pkg::mexp_cmd_t         cmd,
    output mexp_pkg::mexp_status_t      status,
    input  logic [OPERAND_WIDTH-1:0]    base_value,
    input  logic [OPERAND_WIDTH-1:0]    exponent_value,
    input  logic [OPERAND_WIDTH-1:0]    modulus,
    output logic [OPERAND_WIDTH-1:0]    power_result
);

    import mexp_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(2 * W);

    logic [W-1:0]     base_reg;
    logic [W-1:0]     exp_reg;
    logic [W-1:0]     acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [2*W-1:0]   prod_mul;
    logic [2*W-1:0]   prod_sqr;
    logic [W-1:0]     rem_mul;
    logic [W-1:0]     rem_sqr;

    // Both products use the current base, so they are formed and reduced
    // side by side.
    assign prod_mul = {{W{1'b0}}, acc_reg} * {{W{1'b0}}, base_reg};
    assign prod_sqr = {{W{1'b0}}, base_reg} * {{W{1'b0}}, base_reg};

    mexp_modred #(
        .OPERAND_WIDTH(W)
    ) u_red_mul (
        .clk      (clk),
        .load     (cmd.red_start),
        .step     (cmd.red_step),
        .product  (prod_mul),
        .modulus  (modulus),
        .remainder(rem_mul)
    );

    mexp_modred #(
        .OPERAND_WIDTH(W)
    ) u_red_sqr (
        .clk      (clk),
        .load     (cmd.red_start),
        .step     (cmd.red_step),
        .product  (prod_sqr),
        .modulus  (modulus),
        .remainder(rem_sqr)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.red_start)
        begin
            cnt_next = '0;
        end
        else if (cmd.red_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_value;
            exp_reg  <= exponent_value;
            acc_reg  <= W'(1);
        end
        else if (cmd.clear_acc)
        begin
            acc_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (exp_reg[0])
            begin
                acc_reg <= rem_mul;
            end
            base_reg <= rem_sqr;
            exp_reg  <= {1'b0, exp_reg[W-1:1]};
        end
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.mod_zero = (modulus == '0);
    assign status.red_last = (cnt_reg == CNT_W'(2 * W - 1));
    assign power_result    = acc_reg;

endmodule

// ===== rtl/core/mexp_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mexp_ctrl
// Sequencer for the square-and-multiply loop.
// ============================================================================
module mexp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  mexp_pkg::mexp_status_t status,
    output mexp_pkg::mexp_cmd_t    cmd,
    output logic                   busy,
    output logic                   done
);

    import mexp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_RED    = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.mod_zero)
                begin
                    cmd.clear_acc = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.red_start = 1'b1;
                state_next    = ST_RED;
            end
            ST_RED:
            begin
                cmd.red_step = 1'b1;
                if (status.red_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_FINISH);

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ============================================================================
// modular_exponentiation
// Computes base_value ** exponent_value mod modulus by square-and-multiply.
// ============================================================================
// Usage: a transaction is started by raising start with base_value and
// exponent_value while busy is low; the operands are captured at that edge.
// Exactly one result follows: power_result is valid for the single cycle in
// which done is high, and the receiver must take it then, as it cannot stall.
// busy stays high from the accepted start until the cycle after done.
// The modulus lives in an APB register at byte address 0 (pready is tied
// high); it may only be changed while busy is low and resets to 23.
// Each pass of the loop handles one exponent bit, from the lowest up to the
// highest set bit: the check state, then the multiply state loading the two
// bit-serial reducers, the reduce state stepping them one remainder bit at a
// time over the double-width products, and the update state. A zero exponent
// or a zero modulus goes from the check state straight to the finish state.
// One transaction is worked on at a time. Reset returns the sequencer to
// idle and drops any transaction in flight.
// ============================================================================
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mexp_pkg::ADDR_W-1:0]   paddr,
    input  logic [mexp_pkg::DATA_W-1:0]   pwdata,
    output logic [mexp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [OPERAND_WIDTH-1:0]      base_value,
    input  logic [OPERAND_WIDTH-1:0]      exponent_value,
    output logic                          done,
    output logic [OPERAND_WIDTH-1:0]      power_result
);

    import mexp_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0] modulus_reg;
    logic [W-1:0] modulus_next;
    logic         cfg_write;
    logic         start_accept;
    mexp_cmd_t    cmd;
    mexp_status_t status;

    // The register decode uses the word bit only; the byte offset is ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_write && (paddr[2] == REG_MODULUS))
        begin
            modulus_next = pwdata[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= W'(MODULUS_RESET);
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    // Reads of any address other than the modulus return zero.
    assign prdata = (paddr[2] == REG_MODULUS) ? DATA_W'(modulus_reg) : '0;

    // The controller only looks at start while idle, which is the accept rule.
    assign start_accept = start && !busy;

    mexp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_accept),
        .status(status),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mexp_datapath #(
        .OPERAND_WIDTH(W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .base_value    (base_value),
        .exponent_value(exponent_value),
        .modulus       (modulus_reg),
        .power_result  (power_result)
    );

endmodule
